>>> rtl/qau_pkg.sv
package qau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 4;
  localparam int SQ_WIDTH   = DATA_WIDTH + 2;
  localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS;
  localparam int QUO_WIDTH  = NUM_WIDTH;
  localparam int ROOT_WIDTH = DATA_WIDTH + 1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic [2:0]                   op_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_MUL  = 3'd1;
  localparam op_t OP_CONJ = 3'd2;
  localparam op_t OP_MAG  = 3'd3;
  localparam op_t OP_NORM = 3'd4;
  localparam op_t OP_INV  = 3'd5;
  localparam op_t OP_ROT  = 3'd6;
  localparam op_t OP_NONE = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam word_t MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    word_t      v;
    logic       sat;
  } fit_t;

  // clamp a wide signed value to the word range
  function automatic fit_t fit_acc(input acc_t v);
    fit_t r;
    r.sat = 1'b0;
    r.v = v[DATA_WIDTH-1:0];
    if (v > acc_t'(MAXV)) begin
      r.v = MAXV;
      r.sat = 1'b1;
    end else if (v < acc_t'(MINV)) begin
      r.v = MINV;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // twice-fraction value to word, round half up, saturate
  function automatic fit_t rescale(input acc_t v);
    acc_t t;
    t = (v + (acc_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return fit_acc(t);
  endfunction

endpackage

>>> rtl/quaternion_arithmetic_unit_top.sv
// Quaternion unit in signed Q16.16. A request enters every cycle the pipeline is not
// stalled; on its way from the accepting edge to its first result each passes through
// one product stage, one sum stage, 33 square-root stages, 48 divider stages and the
// output register (every operation walks the same path so results leave in order).
// A stalled result holds the whole pipeline and the input. Add, multiply, conjugate,
// magnitude, normalise and inverse give one result; the rotation matrix gives three
// rows, and the output stage holds the pipeline while it issues the second and third,
// so a matrix request keeps new requests out until its third row has been issued.
// Zero norm gives zeros and status 1; overflow saturates and gives status 2.
module quaternion_arithmetic_unit_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          req_type,
  input  qau_pkg::word_t      a_w,
  input  qau_pkg::word_t      a_x,
  input  qau_pkg::word_t      a_y,
  input  qau_pkg::word_t      a_z,
  input  qau_pkg::word_t      b_w,
  input  qau_pkg::word_t      b_x,
  input  qau_pkg::word_t      b_y,
  input  qau_pkg::word_t      b_z,
  output logic                out_valid,
  input  logic                out_stall,
  output qau_pkg::word_t      res_0,
  output qau_pkg::word_t      res_1,
  output qau_pkg::word_t      res_2,
  output qau_pkg::word_t      res_3,
  output logic [1:0]          status,
  output logic                last
);
  import qau_pkg::*;

  localparam int SQ_LAT  = ROOT_WIDTH;
  localparam int DIV_LAT = NUM_WIDTH;

  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  typedef struct packed {
    op_t   op;
    word_t aw, ax, ay, az;
    word_t bw, bx, by, bz;
  } req_t;

  // stage 1: products
  typedef struct packed {
    op_t   op;
    word_t aw, ax, ay, az;
    word_t bw, bx, by, bz;
    prod_t [15:0] p;
    prod_t [9:0]  q;
  } s1_t;

  // stage 2: final results of the short operations, rotation matrix entries, sum of squares
  typedef struct packed {
    op_t   op;
    word_t aw, ax, ay, az;
    word_t [3:0] r;
    logic  sat;
    word_t [8:0] m;
    logic  [2:0] msat;
    logic  [PROD_WIDTH+1:0] ss;
  } s2_t;

  typedef struct packed {
    op_t   op;
    word_t [3:0] r;
    logic  [1:0] st;
    word_t [8:0] m;
    logic  [2:0] msat;
  } ob_t;
  ob_t obuf, onext;

  logic adv;
  logic [1:0] row;
  logic hold;

  // pipeline advances unless the output register is full and blocked,
  // or a matrix is still being issued
  assign hold = out_valid && (out_stall || (obuf.op == OP_ROT && row != 2'd2));
  assign adv  = !hold;
  assign in_stall = !adv;

  // ---------------- stage 1
  req_t  rq;
  s1_t   s1;
  logic  v1;
  assign rq = '{req_type, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.op <= rq.op;
      s1.aw <= rq.aw; s1.ax <= rq.ax; s1.ay <= rq.ay; s1.az <= rq.az;
      s1.bw <= rq.bw; s1.bx <= rq.bx; s1.by <= rq.by; s1.bz <= rq.bz;
      // hamilton product terms
      s1.p[0]  <= rq.aw * rq.bw; s1.p[1]  <= rq.ax * rq.bx;
      s1.p[2]  <= rq.ay * rq.by; s1.p[3]  <= rq.az * rq.bz;
      s1.p[4]  <= rq.aw * rq.bx; s1.p[5]  <= rq.ax * rq.bw;
      s1.p[6]  <= rq.ay * rq.bz; s1.p[7]  <= rq.az * rq.by;
      s1.p[8]  <= rq.aw * rq.by; s1.p[9]  <= rq.ax * rq.bz;
      s1.p[10] <= rq.ay * rq.bw; s1.p[11] <= rq.az * rq.bx;
      s1.p[12] <= rq.aw * rq.bz; s1.p[13] <= rq.ax * rq.by;
      s1.p[14] <= rq.ay * rq.bx; s1.p[15] <= rq.az * rq.bw;
      // squares and cross terms of A
      s1.q[0] <= rq.aw * rq.aw; s1.q[1] <= rq.ax * rq.ax;
      s1.q[2] <= rq.ay * rq.ay; s1.q[3] <= rq.az * rq.az;
      s1.q[4] <= rq.ax * rq.ay; s1.q[5] <= rq.aw * rq.az;
      s1.q[6] <= rq.ax * rq.az; s1.q[7] <= rq.aw * rq.ay;
      s1.q[8] <= rq.ay * rq.az; s1.q[9] <= rq.aw * rq.ax;
    end
  end

  // ---------------- stage 2
  s2_t  s2n, s2;
  logic v2;

  function automatic acc_t ax(input prod_t p);
    return acc_t'(p);
  endfunction

  always_comb begin
    fit_t f0, f1, f2, f3;
    acc_t one;
    acc_t sq;
    s2n = '0;
    s2n.op = s1.op;
    s2n.aw = s1.aw; s2n.ax = s1.ax; s2n.ay = s1.ay; s2n.az = s1.az;
    one = acc_t'(1) <<< (2 * FRAC_BITS);
    sq = ax(s1.q[0]) + ax(s1.q[1]) + ax(s1.q[2]) + ax(s1.q[3]);
    s2n.ss = sq[PROD_WIDTH+1:0];
    unique case (s1.op)
      OP_ADD: begin
        f0 = fit_acc(acc_t'(s1.aw) + acc_t'(s1.bw));
        f1 = fit_acc(acc_t'(s1.ax) + acc_t'(s1.bx));
        f2 = fit_acc(acc_t'(s1.ay) + acc_t'(s1.by));
        f3 = fit_acc(acc_t'(s1.az) + acc_t'(s1.bz));
      end
      OP_MUL: begin
        f0 = rescale(ax(s1.p[0]) - ax(s1.p[1]) - ax(s1.p[2]) - ax(s1.p[3]));
        f1 = rescale(ax(s1.p[4]) + ax(s1.p[5]) + ax(s1.p[6]) - ax(s1.p[7]));
        f2 = rescale(ax(s1.p[8]) - ax(s1.p[9]) + ax(s1.p[10]) + ax(s1.p[11]));
        f3 = rescale(ax(s1.p[12]) + ax(s1.p[13]) - ax(s1.p[14]) + ax(s1.p[15]));
      end
      OP_CONJ: begin
        f0 = '{s1.aw, 1'b0};
        f1 = fit_acc(-acc_t'(s1.ax));
        f2 = fit_acc(-acc_t'(s1.ay));
        f3 = fit_acc(-acc_t'(s1.az));
      end
      default: begin
        f0 = '0; f1 = '0; f2 = '0; f3 = '0;
      end
    endcase
    s2n.r[0] = f0.v; s2n.r[1] = f1.v; s2n.r[2] = f2.v; s2n.r[3] = f3.v;
    s2n.sat = f0.sat | f1.sat | f2.sat | f3.sat;
    // rotation matrix entries, row-major
    begin
      fit_t e [9];
      e[0] = rescale(one - 2 * (ax(s1.q[2]) + ax(s1.q[3])));
      e[1] = rescale(2 * (ax(s1.q[4]) - ax(s1.q[5])));
      e[2] = rescale(2 * (ax(s1.q[6]) + ax(s1.q[7])));
      e[3] = rescale(2 * (ax(s1.q[4]) + ax(s1.q[5])));
      e[4] = rescale(one - 2 * (ax(s1.q[1]) + ax(s1.q[3])));
      e[5] = rescale(2 * (ax(s1.q[8]) - ax(s1.q[9])));
      e[6] = rescale(2 * (ax(s1.q[6]) - ax(s1.q[7])));
      e[7] = rescale(2 * (ax(s1.q[8]) + ax(s1.q[9])));
      e[8] = rescale(one - 2 * (ax(s1.q[1]) + ax(s1.q[2])));
      for (int k = 0; k < 9; k++) s2n.m[k] = e[k].v;
      for (int k = 0; k < 3; k++) s2n.msat[k] = e[3*k].sat | e[3*k+1].sat | e[3*k+2].sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) s2 <= s2n;
  end

  // ---------------- square root, with side data delayed alongside
  logic [ROOT_WIDTH-1:0] root;
  qau_sqrt u_sqrt (.clk(clk), .en(adv), .s(s2.ss), .root(root));

  s2_t  dl1 [0:SQ_LAT];
  logic dv1 [0:SQ_LAT];
  assign dl1[0] = s2;
  assign dv1[0] = v2;
  for (genvar i = 0; i < SQ_LAT; i++) begin : g_d1
    always_ff @(posedge clk) begin
      if (rst) dv1[i+1] <= 1'b0;
      else if (adv) dv1[i+1] <= dv1[i];
    end
    always_ff @(posedge clk) begin
      if (adv) dl1[i+1] <= dl1[i];
    end
  end

  // numerators for the dividers
  s2_t  s3;
  logic [NUM_WIDTH-1:0] num [4];
  logic neg [4];
  word_t comp [4];
  assign s3 = dl1[SQ_LAT];
  assign comp[0] = s3.aw; assign comp[1] = s3.ax;
  assign comp[2] = s3.ay; assign comp[3] = s3.az;

  for (genvar c = 0; c < 4; c++) begin : g_div
    logic [DATA_WIDTH:0] mg;
    fit_t qr;
    always_comb begin
      mg = comp[c][DATA_WIDTH-1] ? -{1'b1, comp[c]} : {1'b0, comp[c]};
      num[c] = NUM_WIDTH'(mg) << FRAC_BITS;
      neg[c] = comp[c][DATA_WIDTH-1] ^ (s3.op == OP_INV && c != 0);
    end
    qau_divider u_div (.clk(clk), .en(adv), .num(num[c]),
                       .den((root == '0) ? ROOT_WIDTH'(1) : root),
                       .neg_in(neg[c]), .res(qr));
  end

  // side data through the divider latency
  typedef struct packed {
    s2_t d;
    logic [ROOT_WIDTH-1:0] rt;
  } sd_t;
  sd_t  dl2 [0:DIV_LAT];
  logic dv2 [0:DIV_LAT];
  assign dl2[0] = '{s3, root};
  assign dv2[0] = dv1[SQ_LAT];
  for (genvar i = 0; i < DIV_LAT; i++) begin : g_d2
    always_ff @(posedge clk) begin
      if (rst) dv2[i+1] <= 1'b0;
      else if (adv) dv2[i+1] <= dv2[i];
    end
    always_ff @(posedge clk) begin
      if (adv) dl2[i+1] <= dl2[i];
    end
  end

  // ---------------- result select
  sd_t  fin;
  logic fv;
  assign fin = dl2[DIV_LAT];
  assign fv  = dv2[DIV_LAT];

  always_comb begin
    fit_t mg;
    logic dsat;
    onext = '0;
    onext.op = fin.d.op;
    onext.m = fin.d.m;
    onext.msat = fin.d.msat;
    mg = fit_acc(acc_t'({1'b0, fin.rt}));
    dsat = g_div[0].qr.sat | g_div[1].qr.sat | g_div[2].qr.sat | g_div[3].qr.sat;
    unique case (fin.d.op)
      OP_ADD, OP_MUL, OP_CONJ: begin
        onext.r = fin.d.r;
        onext.st = fin.d.sat ? ST_SAT : ST_OK;
      end
      OP_MAG: begin
        onext.r[0] = mg.v;
        onext.st = mg.sat ? ST_SAT : ST_OK;
      end
      OP_NORM, OP_INV: begin
        if (fin.rt == '0) begin
          onext.st = ST_ZERO;
        end else begin
          onext.r[0] = g_div[0].qr.v; onext.r[1] = g_div[1].qr.v;
          onext.r[2] = g_div[2].qr.v; onext.r[3] = g_div[3].qr.v;
          onext.st = dsat ? ST_SAT : ST_OK;
        end
      end
      default: onext.st = ST_OK;
    endcase
  end

  // output register and matrix row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row <= '0;
    end else if (adv) begin
      out_valid <= fv;
      row <= '0;
    end else if (out_valid && !out_stall) begin
      row <= row + 2'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) obuf <= onext;
  end

  // drive the visible row
  always_comb begin
    res_0 = obuf.r[0]; res_1 = obuf.r[1]; res_2 = obuf.r[2]; res_3 = obuf.r[3];
    status = obuf.st;
    last = 1'b1;
    if (obuf.op == OP_ROT) begin
      res_3 = '0;
      unique case (row)
        2'd0: begin
          res_0 = obuf.m[0]; res_1 = obuf.m[1]; res_2 = obuf.m[2];
          status = obuf.msat[0] ? ST_SAT : ST_OK;
        end
        2'd1: begin
          res_0 = obuf.m[3]; res_1 = obuf.m[4]; res_2 = obuf.m[5];
          status = obuf.msat[1] ? ST_SAT : ST_OK;
        end
        default: begin
          res_0 = obuf.m[6]; res_1 = obuf.m[7]; res_2 = obuf.m[8];
          status = obuf.msat[2] ? ST_SAT : ST_OK;
        end
      endcase
      last = (row == 2'd2);
    end
  end

endmodule

>>> rtl/qau_divider.sv
// pipelined restoring divider: quotient of a magnitude-scaled component by the norm,
// one quotient bit per stage, with the sign applied at the end
module qau_divider (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [qau_pkg::NUM_WIDTH-1:0]         num,
  input  logic [qau_pkg::ROOT_WIDTH-1:0]        den,
  input  logic                                  neg_in,
  output qau_pkg::fit_t                         res
);
  import qau_pkg::*;

  localparam int N = NUM_WIDTH;
  localparam int RW = ROOT_WIDTH + 1;

  logic [N-1:0]          q   [0:N];
  logic [RW-1:0]         rem [0:N];
  logic [ROOT_WIDTH-1:0] d   [0:N];
  logic                  ng  [0:N];

  assign q[0]   = num;
  assign rem[0] = '0;
  assign d[0]   = den;
  assign ng[0]  = neg_in;

  // one quotient bit per registered stage
  for (genvar i = 0; i < N; i++) begin : g_st
    logic [RW-1:0] sh;
    logic [RW-1:0] df;
    always_comb begin
      sh = {rem[i][RW-2:0], q[i][N-1]};
      df = sh - RW'(d[i]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d[i+1]  <= d[i];
        ng[i+1] <= ng[i];
        if (sh >= RW'(d[i])) begin
          rem[i+1] <= df;
          q[i+1]   <= {q[i][N-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh;
          q[i+1]   <= {q[i][N-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturate
  always_comb begin
    acc_t a;
    a = acc_t'({1'b0, q[N]});
    res = fit_acc(ng[N] ? -a : a);
  end

endmodule

>>> rtl/qau_sqrt.sv
// pipelined integer square root, one root bit per stage (restoring style)
module qau_sqrt (
  input  logic                               clk,
  input  logic                               en,
  input  logic [qau_pkg::PROD_WIDTH+1:0]     s,
  output logic [qau_pkg::ROOT_WIDTH-1:0]     root
);
  import qau_pkg::*;

  localparam int SW = PROD_WIDTH + 2;
  localparam int NB = ROOT_WIDTH;
  localparam int RW = SW + 2;

  logic [SW-1:0]   rad [0:NB];
  logic [RW-1:0]   rem [0:NB];
  logic [NB-1:0]   rt  [0:NB];

  assign rad[0] = s;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  // each stage brings down two radicand bits and decides one root bit
  for (genvar i = 0; i < NB; i++) begin : g_st
    logic [RW-1:0] tr;
    logic [RW-1:0] tt;
    always_comb begin
      tr = {rem[i][RW-3:0], rad[i][SW-1 -: 2]};
      tt = {rt[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad[i+1] <= rad[i] << 2;
        if (tr >= tt) begin
          rem[i+1] <= tr - tt;
          rt[i+1]  <= {rt[i][NB-2:0], 1'b1};
        end else begin
          rem[i+1] <= tr;
          rt[i+1]  <= {rt[i][NB-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[NB];

endmodule
